// ----- rtl/core/price_level_order_book_macros.svh -----
// Assertion macros for the price level order book.
`ifndef PRICE_LEVEL_ORDER_BOOK_MACROS_SVH
`define PRICE_LEVEL_ORDER_BOOK_MACROS_SVH
`ifndef SYNTHESIS
`define PLOB_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define PLOB_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PLOB_ASSERT(label, cond, msg)
`define PLOB_ASSERT_IMP(label, pre, post, msg)
`endif
`endif

// ----- rtl/core/plob_pkg.sv -----
// Package: types, constants and state codes of the order book.
package plob_pkg;
  localparam int LEVELS     = 64;
  localparam int VALUE_BITS = 48;
  localparam int IDX_BITS   = $clog2(LEVELS);
  localparam int CNT_BITS   = $clog2(LEVELS + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_DECIDE, ST_SHIFT, ST_BEST, ST_BEST_WAIT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {OP_NONE, OP_INS, OP_DEL} shift_op_t;

  typedef struct packed {
    logic      load;       // capture input item
    logic      search_start;
    logic      search_step;
    logic      write_size; // overwrite size at hit index
    logic      shift_step;
    shift_op_t shift_op;
    logic      shift_start;
    logic      best_rd;    // issue reads of best entries
    logic      best_cap;   // capture read data
    logic      set_full;
  } ctrl_t;

  typedef struct packed {
    logic search_done;
    logic hit;
    logic is_del;
    logic side_full;
    logic shift_done;
  } stat_t;
endpackage

// ----- rtl/core/plob_if.sv -----
// Valid/ready stream interfaces for update and top-of-book channels.
interface plob_in_if;
  logic               valid;
  logic               ready;
  logic               side;
  plob_pkg::value_t   price;
  plob_pkg::value_t   size;
  modport source (output valid, side, price, size, input ready);
  modport sink   (input valid, side, price, size, output ready);
endinterface

interface plob_out_if;
  logic             valid;
  logic             ready;
  logic             bid_valid;
  plob_pkg::value_t best_bid_price;
  plob_pkg::value_t best_bid_size;
  logic             ask_valid;
  plob_pkg::value_t best_ask_price;
  plob_pkg::value_t best_ask_size;
  logic             table_full;
  modport source (output valid, bid_valid, best_bid_price, best_bid_size, ask_valid,
                  best_ask_price, best_ask_size, table_full, input ready);
  modport sink   (input valid, bid_valid, best_bid_price, best_bid_size, ask_valid,
                  best_ask_price, best_ask_size, table_full, output ready);
endinterface

// ----- rtl/core/plob_ctrl.sv -----
// Sequencer for search, size write, shift and best-of-book read.
module plob_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  plob_pkg::stat_t stat,
  output plob_pkg::ctrl_t ctrl
);
  plob_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= plob_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    ctrl.shift_op = plob_pkg::OP_NONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      plob_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_next = plob_pkg::ST_SEARCH;
        end
      end
      plob_pkg::ST_SEARCH: begin
        ctrl.search_step = 1'b1;
        if (stat.search_done) state_next = plob_pkg::ST_DECIDE;
      end
      plob_pkg::ST_DECIDE: begin
        if (stat.is_del) begin
          if (stat.hit) begin
            ctrl.shift_start = 1'b1;
            ctrl.shift_op = plob_pkg::OP_DEL;
            state_next = plob_pkg::ST_SHIFT;
          end else state_next = plob_pkg::ST_BEST;
        end else if (stat.hit) begin
          ctrl.write_size = 1'b1;
          state_next = plob_pkg::ST_BEST;
        end else if (stat.side_full) begin
          ctrl.set_full = 1'b1;
          state_next = plob_pkg::ST_BEST;
        end else begin
          ctrl.shift_start = 1'b1;
          ctrl.shift_op = plob_pkg::OP_INS;
          state_next = plob_pkg::ST_SHIFT;
        end
      end
      plob_pkg::ST_SHIFT: begin
        ctrl.shift_step = 1'b1;
        if (stat.shift_done) state_next = plob_pkg::ST_BEST;
      end
      plob_pkg::ST_BEST: begin
        ctrl.best_rd = 1'b1;
        state_next = plob_pkg::ST_BEST_WAIT;
      end
      plob_pkg::ST_BEST_WAIT: begin
        ctrl.best_cap = 1'b1;
        state_next = plob_pkg::ST_OUT;
      end
      plob_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = plob_pkg::ST_IDLE;
      end
      default: state_next = plob_pkg::ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/core/plob_dp.sv -----
// Datapath: two sorted level memories, linear search, shift engine, result registers.
module plob_dp (
  input  logic             clk,
  input  logic             rst,
  input  plob_pkg::ctrl_t  ctrl,
  output plob_pkg::stat_t  stat,
  input  logic             in_side,
  input  plob_pkg::value_t in_price,
  input  plob_pkg::value_t in_size,
  output logic             bid_valid,
  output plob_pkg::value_t best_bid_price,
  output plob_pkg::value_t best_bid_size,
  output logic             ask_valid,
  output plob_pkg::value_t best_ask_price,
  output plob_pkg::value_t best_ask_size,
  output logic             table_full
);
  // Per side memory: index {side, level}, price and size in parallel
  localparam int MEM_BITS = plob_pkg::IDX_BITS + 1;
  plob_pkg::value_t mem_price [2*plob_pkg::LEVELS];
  plob_pkg::value_t mem_size  [2*plob_pkg::LEVELS];

  plob_pkg::cnt_t   bid_count, ask_count;
  logic             side;
  plob_pkg::value_t price, size;
  plob_pkg::cnt_t   pos;        // search / shift position
  plob_pkg::cnt_t   hit_pos;
  logic             rd_pending;
  logic             hit;
  logic             done;
  plob_pkg::shift_op_t op;
  // read port
  logic [MEM_BITS-1:0] rd_addr;
  plob_pkg::value_t    rd_price, rd_size;
  logic                rd_en;
  // write port
  logic                wr_en;
  logic [MEM_BITS-1:0] wr_addr;
  plob_pkg::value_t    wr_price, wr_size;
  logic                wr_sz_only;
  // best read, second port
  logic [MEM_BITS-1:0] rd2_addr;
  plob_pkg::value_t    rd2_price, rd2_size;

  plob_pkg::cnt_t count;
  assign count = side ? ask_count : bid_count;

  // search: read pos, compare the registered data in the following cycle
  always_comb begin
    rd_en = 1'b0;
    rd_addr = {side, pos[plob_pkg::IDX_BITS-1:0]};
    if (ctrl.search_step && !done && !rd_pending && pos < count) rd_en = 1'b1;
    if (ctrl.shift_step && !done) begin
      rd_en = 1'b1;
      if (op == plob_pkg::OP_DEL) rd_addr = {side, plob_pkg::IDX_BITS'(pos + 1'b1)};
      else                        rd_addr = {side, plob_pkg::IDX_BITS'(pos - 1'b1)};
    end
    rd2_addr = {1'b0, plob_pkg::IDX_BITS'(bid_count - 1'b1)};
  end

  always_ff @(posedge clk) begin
    // ask best is entry 0, read through port one in the best cycle
    if (ctrl.best_rd) begin
      rd_price  <= mem_price[{1'b1, plob_pkg::IDX_BITS'(0)}];
      rd_size   <= mem_size[{1'b1, plob_pkg::IDX_BITS'(0)}];
      rd2_price <= mem_price[rd2_addr];
      rd2_size  <= mem_size[rd2_addr];
    end else if (rd_en) begin
      rd_price <= mem_price[rd_addr];
      rd_size  <= mem_size[rd_addr];
    end
    if (wr_en) begin
      mem_size[wr_addr] <= wr_size;
      if (!wr_sz_only) mem_price[wr_addr] <= wr_price;
    end
  end

  logic             shift_wr;
  plob_pkg::cnt_t   shift_pos;
  logic             do_last;    // insert: final write of the new level

  always_comb begin
    wr_en = 1'b0;
    wr_sz_only = 1'b0;
    wr_addr = {side, hit_pos[plob_pkg::IDX_BITS-1:0]};
    wr_price = price;
    wr_size = size;
    if (ctrl.write_size) begin
      wr_en = 1'b1;
      wr_sz_only = 1'b1;
    end else if (shift_wr) begin
      wr_en = 1'b1;
      wr_addr = {side, shift_pos[plob_pkg::IDX_BITS-1:0]};
      wr_price = rd_price;
      wr_size = rd_size;
    end else if (do_last) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bid_count <= '0;
      ask_count <= '0;
      rd_pending <= 1'b0;
      done <= 1'b0;
      shift_wr <= 1'b0;
      do_last <= 1'b0;
      op <= plob_pkg::OP_NONE;
    end else begin
      shift_wr <= 1'b0;
      // new level goes in the cycle after the last shifted level is written
      do_last <= shift_wr && done && (op == plob_pkg::OP_INS);
      if (ctrl.load) begin
        side <= in_side;
        price <= in_price;
        size <= in_size;
        pos <= '0;
        rd_pending <= 1'b0;
        done <= 1'b0;
        hit <= 1'b0;
        table_full <= 1'b0;
      end
      if (ctrl.search_step && !done) begin
        if (rd_pending) begin
          rd_pending <= 1'b0;
          if (rd_price < price) pos <= pos + 1'b1;
          else begin
            done <= 1'b1;
            hit <= (rd_price == price);
            hit_pos <= pos;
          end
        end else if (pos < count) rd_pending <= 1'b1;
        else begin
          done <= 1'b1;
          hit_pos <= pos;
        end
      end
      if (ctrl.set_full) table_full <= 1'b1;
      if (ctrl.shift_start) begin
        op <= ctrl.shift_op;
        done <= 1'b0;
        if (ctrl.shift_op == plob_pkg::OP_DEL) begin
          pos <= hit_pos;
          if (hit_pos + 1'b1 >= count) done <= 1'b1;
        end else begin
          pos <= count;
          if (count == hit_pos) begin
            done <= 1'b1;
            do_last <= 1'b1;
          end
        end
      end
      if (ctrl.shift_step && !done) begin
        shift_wr <= 1'b1;
        shift_pos <= pos;
        if (op == plob_pkg::OP_DEL) begin
          pos <= pos + 1'b1;
          if (pos + 2'd2 >= count) done <= 1'b1;
        end else begin
          pos <= pos - 1'b1;
          if (pos - 1'b1 == hit_pos) done <= 1'b1;
        end
      end
      // count changes once the last shift write is done; reads use old count
      if (ctrl.shift_step && done && !shift_wr && !do_last) begin
        if (op == plob_pkg::OP_DEL) begin
          if (side) ask_count <= ask_count - 1'b1;
          else      bid_count <= bid_count - 1'b1;
        end else begin
          if (side) ask_count <= ask_count + 1'b1;
          else      bid_count <= bid_count + 1'b1;
        end
        op <= plob_pkg::OP_NONE;
      end
      if (ctrl.best_cap) begin
        bid_valid <= (bid_count != '0);
        best_bid_price <= (bid_count != '0) ? rd2_price : '0;
        best_bid_size  <= (bid_count != '0) ? rd2_size  : '0;
        ask_valid <= (ask_count != '0);
        best_ask_price <= (ask_count != '0) ? rd_price : '0;
        best_ask_size  <= (ask_count != '0) ? rd_size  : '0;
      end
    end
  end

  assign stat.search_done = done && !ctrl.load;
  assign stat.hit = hit;
  assign stat.is_del = (size == '0);
  assign stat.side_full = (count >= plob_pkg::cnt_t'(plob_pkg::LEVELS));
  assign stat.shift_done = done && !shift_wr && !do_last && (op != plob_pkg::OP_NONE);
endmodule

// ----- rtl/core/price_level_order_book.sv -----
// Top level of the price level order book.
// One update transfer on upd (side, price, size) gives one top-of-book
// transfer on tob: best bid/ask price and size with valid flags, and
// table_full when a new level was dropped because its side held all levels.
// Items are handled one at a time: upd.ready is high only when idle, and the
// next update is taken the cycle after the tob transfer.
// From the update transfer to tob.valid: the search reads and then compares
// each level below the target, a decide state follows, then a removal or an
// insert moves the levels priced above the target through the one write port,
// and both best entries are read (ST_BEST) and captured (ST_BEST_WAIT).
// The result is held in registers until tob.ready; no new update is taken
// while it waits.
// Reset (rst, synchronous) empties both sides; level memories are not cleared,
// as entries at or above a side's count are never used.
`include "price_level_order_book_macros.svh"
module price_level_order_book (
  input logic       clk,
  input logic       rst,
  plob_in_if.sink   upd,
  plob_out_if.source tob
);
  plob_pkg::ctrl_t ctrl;
  plob_pkg::stat_t stat;

  plob_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(upd.valid), .in_ready(upd.ready),
    .out_valid(tob.valid), .out_ready(tob.ready),
    .stat(stat), .ctrl(ctrl)
  );

  plob_dp u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .in_side(upd.side), .in_price(upd.price), .in_size(upd.size),
    .bid_valid(tob.bid_valid), .best_bid_price(tob.best_bid_price),
    .best_bid_size(tob.best_bid_size), .ask_valid(tob.ask_valid),
    .best_ask_price(tob.best_ask_price), .best_ask_size(tob.best_ask_size),
    .table_full(tob.table_full)
  );

  `PLOB_ASSERT(a_no_overlap, !(upd.ready && tob.valid), "input taken while result pending")
  `PLOB_ASSERT_IMP(a_tob_hold, tob.valid && !tob.ready, tob.valid && $stable(tob.best_bid_price), "held result changed")
  `PLOB_ASSERT(a_bid_empty, !(tob.valid && !tob.bid_valid) || tob.best_bid_price == '0, "empty bid with price")
endmodule
